FILE: src/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg - compacting pool allocator shared definitions
// Sizes, field widths, status and function codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int POOL_BYTES    = 1024;
  localparam int TABLE_ENTRIES = 32;
  localparam int ALIGN_BYTES   = 8;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int REQ_W  = 16;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic load;     // latch a new request word
    logic alloc;    // evaluate and commit an allocate
    logic search;   // walk the table looking for the offset
    logic shift;    // compact entries above the freed one
  } cpa_cmd_t;

  typedef struct packed {
    logic hit;       // entry under compare starts at the offset
    logic scan_end;  // no read in flight and no entry left to read
  } cpa_stat_t;

endpackage

FILE: src/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl - allocator sequencer
// Steps a request through allocate, or search and compaction for a free.
// ----------------------------------------------------------------------------
module cpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               func,
  input  cpa_pkg::cpa_stat_t stat,
  output cpa_pkg::cpa_cmd_t  cmd,
  output logic               busy
);
  import cpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SEARCH,
    S_SHIFT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.alloc  = (state_r == S_ALLOC);
    cmd.search = (state_r == S_SEARCH);
    cmd.shift  = (state_r == S_SHIFT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (func == FUNC_FREE) ? S_SEARCH : S_ALLOC;
        end
      end
      S_ALLOC: begin
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (stat.hit) begin
          state_nxt = S_SHIFT;
        end else if (stat.scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (stat.scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

FILE: src/cpa_dp.sv
// ----------------------------------------------------------------------------
// cpa_dp - allocator datapath
// Size table memory, fill count, running byte total, scan pipeline, results.
// ----------------------------------------------------------------------------
module cpa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cpa_pkg::cpa_cmd_t           cmd,
  output cpa_pkg::cpa_stat_t          stat,
  input  logic [cpa_pkg::REQ_W-1:0]   in_request_size,
  input  logic [cpa_pkg::OFF_W-1:0]   in_free_offset,
  output logic                        out_valid,
  output logic [cpa_pkg::STAT_W-1:0]  out_status,
  output logic [cpa_pkg::OFF_W-1:0]   out_alloc_offset,
  output logic [cpa_pkg::LEN_W-1:0]   out_move_src,
  output logic [cpa_pkg::OFF_W-1:0]   out_move_dst,
  output logic [cpa_pkg::LEN_W-1:0]   out_move_len
);
  import cpa_pkg::*;

  // Used entries always form a packed prefix, so start offsets are prefix sums
  // of sizes and only sizes are stored; entries at or above count are empty.
  logic [LEN_W-1:0] size_mem [TABLE_ENTRIES];
  logic [LEN_W-1:0] rd_data_r;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  logic [LEN_W-1:0] wr_data;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             pend_r, pend_nxt;
  logic             vld_r, vld_nxt;

  logic [REQ_W-1:0] req_r, req_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] base_r, base_nxt;
  logic [LEN_W-1:0] removed_r, removed_nxt;

  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OFF_W-1:0]  aoff_r, aoff_nxt;
  logic [LEN_W-1:0]  src_r, src_nxt;
  logic [OFF_W-1:0]  dst_r, dst_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic             rd_more;
  logic             match;
  logic             scan_end;
  logic             bad_size;
  logic [LEN_W-1:0] rounded;
  logic [LEN_W:0]   fill_sum;
  logic [LEN_W-1:0] tail;

  assign rd_more  = (rd_idx_r < count_r);
  assign match    = pend_r && (pos_r == {1'b0, off_r});
  assign scan_end = !pend_r && !rd_more;
  assign bad_size = (req_r == '0) || ({1'b0, req_r} > (REQ_W+1)'(POOL_BYTES));
  assign rounded  = (req_r[LEN_W-1:0] + LEN_W'(ALIGN_BYTES - 1))
                    & ~LEN_W'(ALIGN_BYTES - 1);
  assign fill_sum = {1'b0, total_r} + {1'b0, rounded};
  assign tail     = total_r - base_r - removed_r;

  always_comb begin
    stat          = '0;
    stat.hit      = match;
    stat.scan_end = scan_end;
  end

  always_comb begin
    count_nxt   = count_r;
    total_nxt   = total_r;
    rd_idx_nxt  = rd_idx_r;
    chk_idx_nxt = chk_idx_r;
    pend_nxt    = pend_r;
    vld_nxt     = 1'b0;
    req_nxt     = req_r;
    off_nxt     = off_r;
    pos_nxt     = pos_r;
    base_nxt    = base_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    aoff_nxt    = aoff_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    len_nxt     = len_r;
    we          = 1'b0;
    wr_addr     = count_r[IDX_W-1:0];
    wr_data     = rounded;

    if (cmd.load) begin
      req_nxt    = in_request_size;
      off_nxt    = in_free_offset;
      rd_idx_nxt = '0;
      pend_nxt   = 1'b0;
      pos_nxt    = '0;
    end

    if (cmd.alloc) begin
      vld_nxt    = 1'b1;
      aoff_nxt   = '0;
      src_nxt    = '0;
      dst_nxt    = '0;
      len_nxt    = '0;
      if (bad_size) begin
        status_nxt = ST_BAD_SIZE;
      end else if (count_r == CNT_W'(TABLE_ENTRIES)) begin
        status_nxt = ST_TABLE_FULL;
      end else if (fill_sum > (LEN_W+1)'(POOL_BYTES)) begin
        status_nxt = ST_NO_SPACE;
      end else begin
        status_nxt = ST_OK;
        aoff_nxt   = total_r[OFF_W-1:0];
        we         = 1'b1;
        count_nxt  = count_r + 1'b1;
        total_nxt  = fill_sum[LEN_W-1:0];
      end
    end

    if (cmd.search) begin
      if (match) begin
        base_nxt    = pos_r;
        removed_nxt = rd_data_r;
        rd_idx_nxt  = {1'b0, chk_idx_r} + 1'b1;
        pend_nxt    = 1'b0;
      end else if (scan_end) begin
        vld_nxt    = 1'b1;
        status_nxt = ST_NOT_FOUND;
        aoff_nxt   = '0;
        src_nxt    = '0;
        dst_nxt    = '0;
        len_nxt    = '0;
      end else begin
        if (pend_r) begin
          pos_nxt = pos_r + rd_data_r;
        end
        if (rd_more) begin
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        pend_nxt = rd_more;
      end
    end

    if (cmd.shift) begin
      // entry read last cycle drops one slot down
      if (pend_r) begin
        we      = 1'b1;
        wr_addr = chk_idx_r - 1'b1;
        wr_data = rd_data_r;
      end
      if (scan_end) begin
        vld_nxt    = 1'b1;
        status_nxt = ST_OK;
        aoff_nxt   = '0;
        src_nxt    = '0;
        dst_nxt    = '0;
        len_nxt    = '0;
        if (tail != '0) begin
          src_nxt = base_r + removed_r;
          dst_nxt = base_r[OFF_W-1:0];
          len_nxt = tail;
        end
        count_nxt = count_r - 1'b1;
        total_nxt = total_r - removed_r;
      end else begin
        if (rd_more) begin
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        pend_nxt = rd_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      size_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= size_mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      total_r  <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      vld_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      rd_idx_r <= rd_idx_nxt;
      pend_r   <= pend_nxt;
      vld_r    <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    req_r     <= req_nxt;
    off_r     <= off_nxt;
    pos_r     <= pos_nxt;
    base_r    <= base_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    aoff_r    <= aoff_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    len_r     <= len_nxt;
  end

  assign out_valid        = vld_r;
  assign out_status       = status_r;
  assign out_alloc_offset = aoff_r;
  assign out_move_src     = src_r;
  assign out_move_dst     = dst_r;
  assign out_move_len     = len_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table depth");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= LEN_W'(POOL_BYTES))
    else $error("allocated bytes exceed pool");

  a_total_align: assert property (@(posedge clk) disable iff (!rst_n)
    total_r[$clog2(ALIGN_BYTES)-1:0] == '0)
    else $error("allocated total not aligned");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0))
    else $error("bytes held with no entries");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> !vld_r)
    else $error("result strobe held two cycles");

endmodule

FILE: src/compacting_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// compacting_pool_allocator_unit - compacting pool allocator top level
// Allocation table for a byte pool; frees compact the table and report a move.
// ----------------------------------------------------------------------------
// Allocate: result strobe registered from the allocate state; busy for one cycle.
// Free: one table entry per cycle through the size memory's single read port,
//   search then compaction.
// A new word is accepted in the cycle its predecessor's result is shown.
// Results cannot be stalled. Synchronous reset empties the table at once
// (fill count cleared); no clearing pass.
module compacting_pool_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [cpa_pkg::REQ_W-1:0]   in_request_size,
  input  logic [cpa_pkg::OFF_W-1:0]   in_free_offset,
  output logic                        out_valid,
  output logic [cpa_pkg::STAT_W-1:0]  out_status,
  output logic [cpa_pkg::OFF_W-1:0]   out_alloc_offset,
  output logic [cpa_pkg::LEN_W-1:0]   out_move_src,
  output logic [cpa_pkg::OFF_W-1:0]   out_move_dst,
  output logic [cpa_pkg::LEN_W-1:0]   out_move_len
);
  import cpa_pkg::*;

  cpa_cmd_t  cmd;
  cpa_stat_t stat;

  cpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cpa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_request_size  (in_request_size),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset),
    .out_move_src     (out_move_src),
    .out_move_dst     (out_move_dst),
    .out_move_len     (out_move_len)
  );

endmodule
